/* sv/jtld_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Jump detector package
// Shared types, widths and codes for the jump takeoff and landing detector.
// ----------------------------------------------------------------------------
package jtld_pkg;

   localparam int SAMPLE_BITS    = 10;
   localparam int THRESH_BITS    = 10;
   localparam int WINDOW_BITS    = 16;
   localparam int STAMP_BITS     = 32;
   localparam int PHASE_BITS     = 3;
   localparam int CMP_BITS       = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(1000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORCE_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_WINDOW_MS = 1'b1;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_GROUND     = 3'd0,
      PH_MAYBE_UP   = 3'd1,
      PH_AIR        = 3'd2,
      PH_MAYBE_DOWN = 3'd3,
      PH_LANDED     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [STAMP_BITS-1:0]  now_ms;
      logic                   clear;
   } req_type;

   typedef struct packed {
      logic                   jumped;
      logic                   landed;
      logic                   ready_res;
      logic [STAMP_BITS-1:0]  air_time_ms;
      logic [SAMPLE_BITS-1:0] peak_takeoff;
      logic [SAMPLE_BITS-1:0] peak_landing;
      logic [PHASE_BITS-1:0]  phase_now;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/jump_takeoff_landing_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Jump takeoff and landing detector
// Five-phase detector on force samples that reports takeoff, landing, air
// time and peak forces, with one result per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_data (sample, now_ms, clear)
// rsp       out        rsp_valid/rsp_stall  rsp_data (flags, air time, peaks)
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Each request's result is registered in the output register in the cycle
// after acceptance, and a new request is accepted every cycle unless stalled.
// The request side stalls only while the output register holds a result that
// the response side stalls.
// Synchronous reset restores the threshold and settle window and returns to the grounded phase.
// ----------------------------------------------------------------------------
module jump_takeoff_landing_detector
   import jtld_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire req_type                   req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      rsp_type                   rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [THRESH_BITS-1:0] thresh_ff;
   logic [WINDOW_BITS-1:0] window_ff;

   phase_type              phase_ff, phase_in, phase_base;
   logic [STAMP_BITS-1:0]  takeoff_ff, takeoff_in, takeoff_base;
   logic [STAMP_BITS-1:0]  landing_ff, landing_in, landing_base;
   logic [STAMP_BITS-1:0]  air_ff, air_in, air_base;
   logic [SAMPLE_BITS-1:0] peak_up_ff, peak_up_in, peak_up_base;
   logic [SAMPLE_BITS-1:0] peak_down_ff, peak_down_in, peak_down_base;
   logic                   jumped_ff, jumped_in, jumped_base;
   logic                   landed_ff, landed_in, landed_base;
   logic                   ready_ff, ready_in, ready_base;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff;

   logic                   accept;
   logic                   below, above, in_window;
   logic [STAMP_BITS-1:0]  since_landing;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORCE_THRESHOLD:  thresh_ff <= csr_wdata[THRESH_BITS-1:0];
            CSR_SETTLE_WINDOW_MS: window_ff <= csr_wdata[WINDOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A clear request zeroes the detector before its sample is processed.
   always_comb begin
      phase_base     = req_data.clear ? PH_GROUND : phase_ff;
      takeoff_base   = req_data.clear ? '0 : takeoff_ff;
      landing_base   = req_data.clear ? '0 : landing_ff;
      air_base       = req_data.clear ? '0 : air_ff;
      peak_up_base   = req_data.clear ? '0 : peak_up_ff;
      peak_down_base = req_data.clear ? '0 : peak_down_ff;
      jumped_base    = req_data.clear ? 1'b0 : jumped_ff;
      landed_base    = req_data.clear ? 1'b0 : landed_ff;
      ready_base     = req_data.clear ? 1'b0 : ready_ff;
   end

   assign below = CMP_BITS'(req_data.sample) < CMP_BITS'(thresh_ff);
   assign above = CMP_BITS'(req_data.sample) > CMP_BITS'(thresh_ff);
   assign since_landing = req_data.now_ms - landing_base;
   assign in_window = since_landing < STAMP_BITS'(window_ff);

   always_comb begin
      unique case (phase_base)
         PH_MAYBE_UP:   phase_in = below ? PH_AIR : PH_GROUND;
         PH_AIR:        phase_in = above ? PH_MAYBE_DOWN : PH_AIR;
         PH_MAYBE_DOWN: phase_in = above ? PH_LANDED : PH_AIR;
         PH_LANDED:     phase_in = PH_LANDED;
         default:       phase_in = below ? PH_MAYBE_UP : PH_GROUND;
      endcase
   end

   always_comb begin
      takeoff_in   = takeoff_base;
      landing_in   = landing_base;
      air_in       = air_base;
      peak_up_in   = peak_up_base;
      peak_down_in = peak_down_base;
      jumped_in    = jumped_base;
      landed_in    = landed_base;
      ready_in     = ready_base;
      unique case (phase_base)
         PH_MAYBE_UP: begin
            if (req_data.sample > peak_up_base) peak_up_in = req_data.sample;
            if (below) begin
               takeoff_in = req_data.now_ms;
               jumped_in  = 1'b1;
            end
         end
         PH_AIR: ;
         PH_MAYBE_DOWN: begin
            if (above) begin
               air_in     = req_data.now_ms - takeoff_base;
               landing_in = req_data.now_ms;
               landed_in  = 1'b1;
               if (req_data.sample > peak_down_base) peak_down_in = req_data.sample;
            end
         end
         PH_LANDED: begin
            if (in_window) begin
               if (req_data.sample > peak_down_base) peak_down_in = req_data.sample;
            end else begin
               ready_in = 1'b1;
            end
         end
         default: begin
            if (req_data.sample > peak_up_base) peak_up_in = req_data.sample;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GROUND;
         takeoff_ff   <= '0;
         landing_ff   <= '0;
         air_ff       <= '0;
         peak_up_ff   <= '0;
         peak_down_ff <= '0;
         jumped_ff    <= 1'b0;
         landed_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            takeoff_ff   <= takeoff_in;
            landing_ff   <= landing_in;
            air_ff       <= air_in;
            peak_up_ff   <= peak_up_in;
            peak_down_ff <= peak_down_in;
            jumped_ff    <= jumped_in;
            landed_ff    <= landed_in;
            ready_ff     <= ready_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.jumped       <= jumped_in;
         rsp_data_ff.landed       <= landed_in;
         rsp_data_ff.ready_res    <= ready_in;
         rsp_data_ff.air_time_ms  <= air_in;
         rsp_data_ff.peak_takeoff <= peak_up_in;
         rsp_data_ff.peak_landing <= peak_down_in;
         rsp_data_ff.phase_now    <= phase_in;
      end
   end

endmodule
`default_nettype wire

/* sv/jtld_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Jump detector checker
// Port-level checks on the detector's results, bound to the top level.
// ----------------------------------------------------------------------------
module jtld_checker
   import jtld_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Ready is only reported once a landing has been seen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ready_res |-> rsp_data.landed)
      else $error("ready reported without landing");

   // A landing is only reported after a takeoff.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.landed |-> rsp_data.jumped)
      else $error("landing reported without takeoff");

   // The landed phase always carries the landed flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.phase_now == PH_LANDED) |-> rsp_data.landed)
      else $error("landed phase without landed flag");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind jump_takeoff_landing_detector jtld_checker u_jtld_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* tb/tb_jump_takeoff_landing_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jump takeoff and landing detector testbench
// Drives force samples through the request channel. Well-formed jump
// sequences, directed corner cases and random noise are sent under several
// threshold and settle-window settings. A scoreboard class tracks the
// detector state, predicts each response and compares it field by field.
// Both sides idle at random, and the response side holds off for a long
// stretch at least once.
// ----------------------------------------------------------------------------
module tb_jump_takeoff_landing_detector;
   import jtld_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int IDLE_PERCENT = 22;
   localparam int HOLD_CYCLES  = 60;
   localparam int STUCK_LIMIT  = 1000;
   localparam int PHASE_ITEMS  = 125;

   typedef enum {LEVEL_BELOW, LEVEL_AT, LEVEL_ABOVE, LEVEL_ANY} level_type;

   class jump_scoreboard;
      logic [THRESH_BITS-1:0] threshold;
      logic [WINDOW_BITS-1:0] window;
      phase_type              det_phase;
      logic [STAMP_BITS-1:0]  takeoff_stamp;
      logic [STAMP_BITS-1:0]  landing_stamp;
      logic [STAMP_BITS-1:0]  air_time;
      logic [SAMPLE_BITS-1:0] peak_up;
      logic [SAMPLE_BITS-1:0] peak_down;
      logic                   jumped;
      logic                   landed;
      logic                   settled;
      rsp_type                due_results[$];
      int                     mismatches;

      function new();
         threshold  = THRESH_RESET;
         window     = WINDOW_RESET;
         mismatches = 0;
         clear_detector();
      endfunction

      function void clear_detector();
         det_phase     = PH_GROUND;
         takeoff_stamp = '0;
         landing_stamp = '0;
         air_time      = '0;
         peak_up       = '0;
         peak_down     = '0;
         jumped        = 1'b0;
         landed        = 1'b0;
         settled       = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_FORCE_THRESHOLD) begin
            threshold = data[THRESH_BITS-1:0];
         end else if (index == CSR_SETTLE_WINDOW_MS) begin
            window = data[WINDOW_BITS-1:0];
         end
      endfunction

      function void note_request(req_type r);
         logic                  below;
         logic                  above;
         logic [STAMP_BITS-1:0] elapsed;
         rsp_type               want;
         if (r.clear) begin
            clear_detector();
         end
         below = r.sample < threshold;
         above = r.sample > threshold;
         case (det_phase)
            PH_MAYBE_UP: begin
               if (r.sample > peak_up) peak_up = r.sample;
               if (below) begin
                  det_phase     = PH_AIR;
                  takeoff_stamp = r.now_ms;
                  jumped        = 1'b1;
               end else begin
                  det_phase = PH_GROUND;
               end
            end
            PH_AIR: begin
               if (above) det_phase = PH_MAYBE_DOWN;
            end
            PH_MAYBE_DOWN: begin
               if (above) begin
                  det_phase     = PH_LANDED;
                  air_time      = r.now_ms - takeoff_stamp;
                  landing_stamp = r.now_ms;
                  landed        = 1'b1;
                  if (r.sample > peak_down) peak_down = r.sample;
               end else begin
                  det_phase = PH_AIR;
               end
            end
            PH_LANDED: begin
               elapsed = r.now_ms - landing_stamp;
               if (elapsed < {16'b0, window}) begin
                  if (r.sample > peak_down) peak_down = r.sample;
               end else begin
                  settled = 1'b1;
               end
            end
            default: begin
               if (r.sample > peak_up) peak_up = r.sample;
               det_phase = below ? PH_MAYBE_UP : PH_GROUND;
            end
         endcase
         want.jumped       = jumped;
         want.landed       = landed;
         want.ready_res    = settled;
         want.air_time_ms  = air_time;
         want.peak_takeoff = peak_up;
         want.peak_landing = peak_down;
         want.phase_now    = det_phase;
         due_results.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("response arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         compare_field("jumped", want.jumped, got.jumped);
         compare_field("landed", want.landed, got.landed);
         compare_field("ready_res", want.ready_res, got.ready_res);
         compare_field("air_time_ms", want.air_time_ms, got.air_time_ms);
         compare_field("peak_takeoff", want.peak_takeoff, got.peak_takeoff);
         compare_field("peak_landing", want.peak_landing, got.peak_landing);
         compare_field("phase_now", want.phase_now, got.phase_now);
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   jump_scoreboard         board;
   bit                     idle_on;
   bit                     hold_request;
   int                     item_count;
   logic [THRESH_BITS-1:0] cur_thr;
   logic [WINDOW_BITS-1:0] cur_win;
   logic [STAMP_BITS-1:0]  clock_ms;

   jump_takeoff_landing_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   initial begin : response_side
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
         end
         @(negedge clock);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      forever begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            stuck = 0;
         end else begin
            stuck++;
         end
         if (stuck >= STUCK_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(input req_type r);
      while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      board.note_request(r);
      item_count++;
      @(posedge clock);
   endtask

   task automatic push_item(input logic [SAMPLE_BITS-1:0] s,
                            input logic [STAMP_BITS-1:0] t, input bit c);
      req_type r;
      r.sample = s;
      r.now_ms = t;
      r.clear  = c;
      send_request(r);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(level_type k);
      case (k)
         LEVEL_BELOW: return (cur_thr == 0) ? '0 : SAMPLE_BITS'($urandom_range(cur_thr - 1, 0));
         LEVEL_AT:    return cur_thr;
         LEVEL_ABOVE: return (cur_thr == 1023) ? 10'd1023 :
                             SAMPLE_BITS'($urandom_range(1023, cur_thr + 1));
         default:     return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [STAMP_BITS-1:0] advance_clock();
      case ($urandom_range(9))
         6, 7:    clock_ms += $urandom_range(2 * cur_win + 2);
         8:       clock_ms += $urandom_range(cur_win + 3, cur_win);
         9:       clock_ms = $urandom;
         default: clock_ms += $urandom_range(40);
      endcase
      return clock_ms;
   endfunction

   task automatic feed(input level_type k, input bit c);
      push_item(pick_sample(k), advance_clock(), c);
   endtask

   task automatic do_jump();
      feed(LEVEL_ABOVE, 1'b1);
      repeat ($urandom_range(3)) feed($urandom_range(1) ? LEVEL_ABOVE : LEVEL_AT, 1'b0);
      if ($urandom_range(3) == 0) begin
         feed(LEVEL_BELOW, 1'b0);
         feed($urandom_range(1) ? LEVEL_ABOVE : LEVEL_AT, 1'b0);
      end
      feed(LEVEL_BELOW, 1'b0);
      feed(LEVEL_BELOW, 1'b0);
      repeat ($urandom_range(4)) feed($urandom_range(1) ? LEVEL_BELOW : LEVEL_AT, 1'b0);
      if ($urandom_range(3) == 0) begin
         feed(LEVEL_ABOVE, 1'b0);
         feed($urandom_range(1) ? LEVEL_BELOW : LEVEL_AT, 1'b0);
      end
      feed(LEVEL_ABOVE, 1'b0);
      feed(LEVEL_ABOVE, 1'b0);
      repeat ($urandom_range(6, 1)) feed(LEVEL_ANY, 1'b0);
   endtask

   task automatic run_phase();
      int start;
      start = item_count;
      while (item_count - start < PHASE_ITEMS) begin
         if ($urandom_range(4) != 0) begin
            do_jump();
         end else begin
            repeat ($urandom_range(6, 1)) feed(LEVEL_ANY, $urandom_range(7) == 0);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      board.write_register(index, data);
      if (index == CSR_FORCE_THRESHOLD) begin
         cur_thr = data[THRESH_BITS-1:0];
      end else begin
         cur_win = data[WINDOW_BITS-1:0];
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [THRESH_BITS-1:0] thr,
                            input logic [WINDOW_BITS-1:0] win);
      drain();
      write_register(CSR_FORCE_THRESHOLD, {6'($urandom), thr});
      write_register(CSR_SETTLE_WINDOW_MS, win);
   endtask

   initial begin : stimulus
      board        = new();
      idle_on      = 1'b1;
      hold_request = 1'b0;
      item_count   = 0;
      cur_thr      = THRESH_RESET;
      cur_win      = WINDOW_RESET;
      clock_ms     = '0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Defaults: threshold 100 and a 1000 ms window. Covers equal samples,
      // false takeoff and landing, wrapped air time, window expiry, a
      // timestamp wrapping back into the window, and clear mid-flight.
      push_item(10'd1023, 32'h0000_0000, 1'b1);
      push_item(10'd100, 32'h0000_0001, 1'b0);
      push_item(10'd0, 32'h0000_0002, 1'b0);
      push_item(10'd100, 32'h0000_0003, 1'b0);
      push_item(10'd0, 32'h0000_0004, 1'b0);
      push_item(10'd0, 32'hFFFF_FFF0, 1'b0);
      push_item(10'd101, 32'hFFFF_FFFF, 1'b0);
      push_item(10'd100, 32'h0000_0005, 1'b0);
      push_item(10'd1023, 32'h0000_0008, 1'b0);
      push_item(10'd500, 32'h0000_0010, 1'b0);
      push_item(10'd900, 32'h0000_0020, 1'b0);
      push_item(10'd1000, 32'h0000_03F8, 1'b0);
      push_item(10'd1023, 32'h0000_0015, 1'b0);
      push_item(10'd2, 32'h0000_0016, 1'b0);
      push_item(10'd50, 32'h0000_0000, 1'b1);
      push_item(10'd0, 32'hAAAA_5555, 1'b0);
      push_item(10'd200, 32'h5555_AAAA, 1'b1);
      run_phase();

      configure(10'd0, 16'd0);
      run_phase();

      configure(10'd1023, 16'hFFFF);
      run_phase();

      configure(10'($urandom_range(1022, 1)), 16'd0);
      idle_on = 1'b0;
      run_phase();
      idle_on = 1'b1;

      configure(10'd512, 16'hFFFF);
      hold_request = 1'b1;
      run_phase();

      configure(10'($urandom_range(1023)), 16'($urandom_range(3000)));
      run_phase();

      drain();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
